// File: rtl/core/pgl_pkg.sv
// shared constants, types and the divide-by-(table size - 1) helper
// for the palette gradient lookup core; no dependencies
`timescale 1ns / 1ps

package pgl_pkg;

   localparam int LUT_ENTRIES   = 256;
   localparam int PALETTE_DEPTH = 16;
   localparam int CHANNEL_BITS  = 16;

   localparam int LUT_D      = LUT_ENTRIES - 1;
   localparam int LUT_HALF_D = LUT_D / 2;

   localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = '1;

   // floor(x / 255) = floor(x * 257 / 65536) or one more, for x below 255 * 2^16
   localparam logic [31:0] RECIP_D     = 32'd257;
   localparam int          RECIP_SHIFT = 16;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic en_mix;
      logic en_out;
   } blend_ctl_type;

   typedef struct packed {
      logic [15:0] quo;
      logic [7:0]  rem;
   } div_res_type;

   function automatic div_res_type div_by_d(input logic [23:0] x);
      logic [31:0] prod;
      logic [15:0] qe;
      logic [23:0] rem_e;
      div_res_type res;
      prod  = 32'(x) * RECIP_D;
      qe    = prod[RECIP_SHIFT +: 16];
      rem_e = x - 24'(qe) * 24'(LUT_D);
      if (rem_e >= 24'(LUT_D)) begin
         res.quo = qe + 16'd1;
         res.rem = 8'(rem_e - 24'(LUT_D));
      end else begin
         res.quo = qe;
         res.rem = 8'(rem_e);
      end
      return res;
   endfunction

endpackage

// File: rtl/core/palette_gradient_lut_core.sv
// palette gradient lookup: up to 16 rgba control colors, linear blend per query
// a query's result item comes out of the four-register pipeline around the palette memory;
// one item per cycle when rsp_stall is low
// a load gives no result item
// reset (synchronous) empties the pipeline and sets the palette count to zero (gray ramp);
// palette memory is not cleared
`timescale 1ns / 1ps

module palette_gradient_lut_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_operation,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic [15:0] req_alpha_in,
   input  logic [7:0]  req_lut_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_index_out,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   output logic [15:0] rsp_alpha_out
);

   localparam int NUM_CHAN = 4;

   // palette memory, one rgba word per slot: red in the top 16 bits
   logic [63:0] pal_mem [pgl_pkg::PALETTE_DEPTH];

   // palette count, 0 means gray ramp
   logic [4:0] count_ff;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, vo_ff;

   // per-stage advance, back to front so bubbles collapse
   logic en1, en2, en3, en_o;
   pgl_pkg::blend_ctl_type blend_ctl;

   // accept side
   logic       req_acc;
   logic       load_acc;
   logic       query_acc;
   logic [7:0] idx_clamp;
   logic [3:0] n1_cur;

   // stage 1: clamped index and i*(n-1)
   logic [7:0]  i1_ff;
   logic [11:0] m1_ff;
   logic [11:0] m1_in;
   logic [3:0]  n1_ff;
   logic        gray1_ff;

   // stage 2: palette words and the blend weight
   pgl_pkg::div_res_type seg_div;
   logic [3:0]  k_raw, k_lo, k_hi;
   logic [63:0] rd_a_ff, rd_b_ff;
   logic [7:0]  r2_ff;
   logic [7:0]  i2_ff;
   logic        gray2_ff;

   // stage 3 and output
   logic [7:0]  i3_ff;
   logic [7:0]  idx_ff;
   logic [15:0] mix_a [NUM_CHAN];
   logic [15:0] mix_b [NUM_CHAN];
   logic [15:0] chan_out [NUM_CHAN];
   logic [7:0]  mix_r;

   // --- flow control ---
   assign en_o = !vo_ff || !rsp_stall;
   assign en3  = !v3_ff || en_o;
   assign en2  = !v2_ff || en3;
   assign en1  = !v1_ff || en2;

   assign blend_ctl.en_mix = en3;
   assign blend_ctl.en_out = en_o;

   assign req_stall = !en1;
   assign req_acc   = req_valid && en1;
   assign load_acc  = req_acc && (req_operation == pgl_pkg::OP_LOAD)
                      && ({1'b0, req_slot} < 5'(pgl_pkg::PALETTE_DEPTH));
   assign query_acc = req_acc && (req_operation == pgl_pkg::OP_QUERY);

   // --- stage 1 inputs ---
   // index past the table end clamps to the last entry
   assign idx_clamp = ({1'b0, req_lut_index} > 9'(pgl_pkg::LUT_D))
                      ? 8'(pgl_pkg::LUT_D) : req_lut_index;
   assign n1_cur    = 4'(count_ff - 5'd1);
   assign m1_in     = 12'(idx_clamp) * 12'(n1_cur);

   // --- stage 2: segment k = floor(m/D), weight r = m mod D ---
   always_comb begin
      seg_div = pgl_pkg::div_by_d(24'(m1_ff));
      k_raw   = seg_div.quo[3:0];
      k_lo    = (k_raw > n1_ff) ? n1_ff : k_raw;
      // upper neighbor stops at the last palette entry
      k_hi    = (k_lo >= n1_ff) ? n1_ff : k_lo + 4'd1;
   end

   // --- control state ---
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         vo_ff    <= 1'b0;
      end else begin
         // a load always sets the count, even downward
         if (load_acc) begin
            count_ff <= 5'({1'b0, req_slot} + 5'd1);
         end
         if (en1) begin
            v1_ff <= query_acc;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en_o) begin
            vo_ff <= v3_ff;
         end
      end
   end

   // --- palette memory: one write port, two registered read ports ---
   // a query in stage 1 reads in the same edge a load writes: it sees the old word,
   // which matches item order since the load came later
   always_ff @(posedge clock) begin
      if (load_acc) begin
         pal_mem[req_slot] <= {req_red_in, req_green_in, req_blue_in, req_alpha_in};
      end
      if (en2) begin
         rd_a_ff <= pal_mem[k_lo];
         rd_b_ff <= pal_mem[k_hi];
      end
   end

   // --- payload pipeline ---
   always_ff @(posedge clock) begin
      if (en1) begin
         i1_ff    <= idx_clamp;
         m1_ff    <= m1_in;
         n1_ff    <= n1_cur;
         gray1_ff <= (count_ff == 5'd0);
      end
      if (en2) begin
         r2_ff    <= seg_div.rem;
         i2_ff    <= i1_ff;
         gray2_ff <= gray1_ff;
      end
      if (en3) begin
         i3_ff <= i2_ff;
      end
      if (en_o) begin
         idx_ff <= i3_ff;
      end
   end

   // --- blend operands ---
   // gray ramp is the blend of black to full at weight i; alpha blends full to full
   assign mix_r = gray2_ff ? i2_ff : r2_ff;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      always_comb begin
         if (gray2_ff) begin
            mix_a[c] = (c == NUM_CHAN - 1) ? pgl_pkg::CHAN_FULL : 16'd0;
            mix_b[c] = pgl_pkg::CHAN_FULL;
         end else begin
            mix_a[c] = rd_a_ff[63 - 16*c -: 16];
            mix_b[c] = rd_b_ff[63 - 16*c -: 16];
         end
      end

      pgl_blend u_blend (
         .clock     (clock),
         .ctl       (blend_ctl),
         .color_a   (mix_a[c]),
         .color_b   (mix_b[c]),
         .weight    (mix_r),
         .color_out (chan_out[c])
      );
   end

   // --- response ---
   assign rsp_valid     = vo_ff;
   assign rsp_index_out = idx_ff;
   assign rsp_red_out   = chan_out[0];
   assign rsp_green_out = chan_out[1];
   assign rsp_blue_out  = chan_out[2];
   assign rsp_alpha_out = chan_out[3];

endmodule

// File: rtl/core/pgl_blend.sv
// one color channel: weighted sum of two palette colors, then rounded
// divide by the table span; uses pgl_pkg
`timescale 1ns / 1ps

module pgl_blend (
   input  logic                  clock,
   input  pgl_pkg::blend_ctl_type ctl,
   input  logic [15:0]           color_a,
   input  logic [15:0]           color_b,
   input  logic [7:0]            weight,
   output logic [15:0]           color_out
);

   logic [23:0] num_ff;
   logic [23:0] num_in;
   logic [15:0] color_ff;
   pgl_pkg::div_res_type dv;

   // a*(D-r) + b*r + D/2
   always_comb begin
      num_in = 24'(color_a) * 24'(8'(pgl_pkg::LUT_D) - weight)
             + 24'(color_b) * 24'(weight)
             + 24'(pgl_pkg::LUT_HALF_D);
      dv     = pgl_pkg::div_by_d(num_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_mix) begin
         num_ff <= num_in;
      end
      if (ctl.en_out) begin
         color_ff <= dv.quo;
      end
   end

   assign color_out = color_ff;

endmodule

// File: rtl/core/pgl_checker.sv
// port-level checks for palette_gradient_lut_core, attached by bind;
// depends on the top level's port list only
`timescale 1ns / 1ps

module pgl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [0:0]  req_operation,
   input logic [3:0]  req_slot,
   input logic [15:0] req_red_in,
   input logic [15:0] req_green_in,
   input logic [15:0] req_blue_in,
   input logic [15:0] req_alpha_in,
   input logic [7:0]  req_lut_index,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_index_out,
   input logic [15:0] rsp_red_out,
   input logic [15:0] rsp_green_out,
   input logic [15:0] rsp_blue_out,
   input logic [15:0] rsp_alpha_out
);

   // input only backs up when the result side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked result item");

   // reset empties the pipeline and frees the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_index_out)
         && $stable(rsp_red_out) && $stable(rsp_green_out)
         && $stable(rsp_blue_out) && $stable(rsp_alpha_out)))
      else $error("stalled result item changed");

   // a stalled request item holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_operation)
         && $stable(req_slot) && $stable(req_red_in) && $stable(req_green_in)
         && $stable(req_blue_in) && $stable(req_alpha_in)
         && $stable(req_lut_index)))
      else $error("stalled request item changed");

endmodule

bind palette_gradient_lut_core pgl_checker u_pgl_checker (.*);
